@@ sv/vcr_pkg.sv @@
// Package for the viewport clamp to region unit: field widths, register indexes,
// slot and axis request types, and the span test and saturation helpers.
// Depends on nothing.
package vcr_pkg;

    localparam int REGION_SLOTS_DEF = 8;

    localparam int COORD_W = 24;
    localparam int SPAN_W  = 23;
    localparam int WIDE_W  = 27;
    localparam int IDX_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [SPAN_W-1:0] HALF_WIDTH_RST = 23'd5120;
    localparam logic [SPAN_W-1:0] UPPER_SPAN_RST = 23'd3840;
    localparam logic [SPAN_W-1:0] LOWER_SPAN_RST = 23'd1920;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_SPAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_SPAN = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [SPAN_W-1:0]  t_span;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_span  width;
        t_span  height;
    } t_slot;

    // one axis: centre p, span [lo, lo+len), edges p-a-b and p+c-b
    typedef struct packed {
        t_coord p;
        t_coord lo;
        t_span  len;
        t_span  a;
        t_span  c;
        t_coord b;
    } t_axis_req;

    function automatic t_wide wide_s(input t_coord v);
        return WIDE_W'(v);
    endfunction

    function automatic t_wide wide_u(input t_span v);
        return $signed(WIDE_W'(v));
    endfunction

    function automatic logic holds(input t_wide lo, input t_wide len, input t_wide p);
        t_wide hi;
        hi = lo + len;
        return (p >= lo) && (p < hi);
    endfunction

    function automatic t_coord sat24(input t_wide v);
        t_wide vmax;
        t_wide vmin;
        vmax = $signed(WIDE_W'(24'sh7FFFFF));
        vmin = -vmax - t_wide'(1);
        if (v > vmax) begin
            return t_coord'(vmax);
        end else if (v < vmin) begin
            return t_coord'(vmin);
        end
        return t_coord'(v);
    endfunction

endpackage

@@ sv/viewport_clamp_to_region_unit.sv @@
// Viewport clamp to region: slot table in a RAM, walked one slot at a time.
// Load beat: written to the table if in range, no result. Query beat: slots are read
// and tested in order until a hit (x then y axis clamped) or a miss on the last
// slot, then DONE posts the result. One item at a time, next beat taken the
// cycle after the result is posted; a waiting result holds a finished query in DONE.
// Synchronous reset clears valid bits and loads config with its reset values.
module viewport_clamp_to_region_unit #(
    parameter int REGION_SLOTS = vcr_pkg::REGION_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vcr_pkg::SPAN_W-1:0]         i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_kind,
    input  logic [vcr_pkg::IDX_W-1:0]          i_entry_index,
    input  logic                               i_entry_enable,
    input  logic signed [vcr_pkg::COORD_W-1:0] i_region_left,
    input  logic signed [vcr_pkg::COORD_W-1:0] i_region_top,
    input  logic [vcr_pkg::SPAN_W-1:0]         i_region_width,
    input  logic [vcr_pkg::SPAN_W-1:0]         i_region_height,
    input  logic signed [vcr_pkg::COORD_W-1:0] i_cam_x,
    input  logic signed [vcr_pkg::COORD_W-1:0] i_cam_y,
    input  logic signed [vcr_pkg::COORD_W-1:0] i_focus_offset,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vcr_pkg::COORD_W-1:0] o_x_out,
    output logic signed [vcr_pkg::COORD_W-1:0] o_y_out,
    output logic                               o_corrected,
    output logic                               o_found
);
    import vcr_pkg::*;

    localparam int AW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_XAX  = 3'd3;
    localparam logic [2:0] S_YAX  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_idx;
    logic [REGION_SLOTS-1:0] r_valid;
    t_span                   r_half, r_upper, r_lower;
    t_coord                  r_x, r_y, r_f, r_nx, r_ny;
    logic                    r_fire, r_found;
    t_slot                   r_slot;
    logic                    r_out_valid;
    t_coord                  r_out_x, r_out_y;
    logic                    r_out_corr, r_out_found;

    logic      w_accept, w_load, w_in_range, w_hit, w_last, w_out_free;
    logic [AW-1:0] w_waddr;
    t_slot     w_wslot, w_rslot;
    t_axis_req w_req;
    t_coord    w_axis_value;
    logic      w_axis_fired;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (32'(i_entry_index) < REGION_SLOTS);
    assign w_load     = w_accept && (i_kind == KIND_LOAD) && w_in_range;
    assign w_waddr    = AW'(i_entry_index);
    assign w_wslot    = '{left: i_region_left, top: i_region_top,
                          width: i_region_width, height: i_region_height};
    assign w_last     = (r_idx == AW'(REGION_SLOTS - 1));
    assign w_out_free = !r_out_valid || i_ready;

    vcr_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (REGION_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_waddr),
        .i_wdata (w_wslot),
        .i_raddr (r_idx),
        .o_rdata (w_rslot)
    );

    assign w_hit = r_valid[r_idx]
                && holds(wide_s(w_rslot.left), wide_u(w_rslot.width), wide_s(r_x))
                && holds(wide_s(w_rslot.top), wide_u(w_rslot.height), wide_s(r_y));

    always_comb begin
        if (r_state == S_YAX) begin
            w_req = '{p: r_y, lo: r_slot.top, len: r_slot.height,
                      a: r_upper, c: r_lower, b: '0};
        end else begin
            w_req = '{p: r_x, lo: r_slot.left, len: r_slot.width,
                      a: r_half, c: r_half, b: r_f};
        end
    end

    vcr_axis u_axis (
        .i_req   (w_req),
        .o_value (w_axis_value),
        .o_fired (w_axis_fired)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_kind == KIND_QUERY)) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_TEST;
            S_TEST: begin
                if (w_hit) begin
                    n_state = S_XAX;
                end else if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_XAX: n_state = S_YAX;
            S_YAX: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_half      <= HALF_WIDTH_RST;
            r_upper     <= UPPER_SPAN_RST;
            r_lower     <= LOWER_SPAN_RST;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_valid[w_waddr] <= i_entry_enable;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HALF_WIDTH: r_half  <= i_cfg_wdata;
                    CFG_UPPER_SPAN: r_upper <= i_cfg_wdata;
                    CFG_LOWER_SPAN: r_lower <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_x   <= i_cam_x;
                r_y   <= i_cam_y;
                r_f   <= i_focus_offset;
            end
            S_TEST: begin
                r_slot <= w_rslot;
                if (w_hit) begin
                    r_found <= 1'b1;
                end else begin
                    r_idx   <= r_idx + AW'(1);
                    r_found <= 1'b0;
                    r_nx    <= r_x;
                    r_ny    <= r_y;
                    r_fire  <= 1'b0;
                end
            end
            S_XAX: begin
                r_nx   <= w_axis_value;
                r_fire <= w_axis_fired;
            end
            S_YAX: begin
                r_ny   <= w_axis_value;
                r_fire <= r_fire || w_axis_fired;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_x     <= r_nx;
                    r_out_y     <= r_ny;
                    r_out_corr  <= r_fire;
                    r_out_found <= r_found;
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_x_out     = r_out_x;
    assign o_y_out     = r_out_y;
    assign o_corrected = r_out_corr;
    assign o_found     = r_out_found;

endmodule

@@ sv/vcr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vcr_axis.sv @@
// One-axis edge check and clamp: low check first, high check only if it passes.
// Depends on vcr_pkg.
module vcr_axis (
    input  vcr_pkg::t_axis_req i_req,
    output vcr_pkg::t_coord    o_value,
    output logic               o_fired
);
    import vcr_pkg::*;

    t_wide w_p, w_lo, w_len, w_a, w_c, w_b;
    t_wide w_edge_lo, w_edge_hi, w_v1, w_v2;
    logic  w_in_lo, w_in_hi;

    always_comb begin
        w_p   = wide_s(i_req.p);
        w_lo  = wide_s(i_req.lo);
        w_len = wide_u(i_req.len);
        w_a   = wide_u(i_req.a);
        w_c   = wide_u(i_req.c);
        w_b   = wide_s(i_req.b);

        w_edge_lo = w_p - w_a - w_b;
        w_edge_hi = w_p + w_c - w_b;
        w_v1      = w_lo + w_a + w_b;
        w_v2      = w_lo + w_len - w_c + w_b;

        w_in_lo = holds(w_lo, w_len, w_edge_lo);
        w_in_hi = holds(w_lo, w_len, w_edge_hi);

        priority if (!w_in_lo) begin
            o_value = sat24(w_v1);
        end else if (!w_in_hi) begin
            o_value = sat24(w_v2);
        end else begin
            o_value = i_req.p;
        end
        o_fired = !w_in_lo || !w_in_hi;
    end

endmodule
